[design/sll_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// sll_pkg
// Shared types and constants for the static linked list engine: item codes,
// status codes, sequencer states and the storage write-enable group.
// ============================================================================
package sll_pkg;

   // Fixed widths of the transfer payload fields.
   localparam int KIND_WIDTH   = 2;
   localparam int POS_WIDTH    = 7;
   localparam int WORD_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;

   // Node 1 is the list head; node 0 is the null link.
   localparam int HEAD_NODE  = 1;
   localparam int FIRST_FREE = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_READ   = 2'd3
   } sll_kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_POS = 2'd1,
      STATUS_FULL    = 2'd2
   } sll_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_INS,
      ST_INS_LINK,
      ST_DEL,
      ST_DEL_LINK,
      ST_RESP
   } sll_state_type;

   // Write enables for the node storage.
   typedef struct packed {
      logic link_we;
      logic data_we;
   } sll_wr_en_type;

endpackage

[design/sll_req_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// sll_req_if
// Request channel: operation kind, list position and the value to insert.
// ============================================================================
interface sll_req_if;
   import sll_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_WIDTH-1:0] kind;
   logic [POS_WIDTH-1:0]  position;
   logic signed [WORD_WIDTH-1:0] new_value;

   modport source (output valid, kind, position, new_value, input ready);
   modport sink   (input valid, kind, position, new_value, output ready);

endinterface

[design/sll_rsp_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// sll_rsp_if
// Response channel: status code and the value read or removed.
// ============================================================================
interface sll_rsp_if;
   import sll_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic signed [WORD_WIDTH-1:0] read_value;

   modport source (output valid, status, read_value, input ready);
   modport sink   (input valid, status, read_value, output ready);

endinterface

[design/static_linked_list_engine.sv]
`timescale 1ns / 1ps
// Clear and read of position 0 go straight to the response; other items first walk
// the list up to the position, and the response can stall until it is taken.
// Throughput: one item at a time; the walk follows one link per cycle through the
// single read port of the link memory, so the walk length sets the item time.
// Reset: synchronous; the list comes up empty with all nodes free, and no
// clearing pass is needed (unused nodes are handed out from a fill mark).
// ============================================================================
// static_linked_list_engine
// One list kept in a fixed node array with a free chain. A small sequencer
// walks the link memory one node per cycle, then patches links in place.
// ============================================================================
module static_linked_list_engine #(
   parameter int NODE_COUNT  = 128,
   parameter int VALUE_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   sll_req_if.sink   req_ch,
   sll_rsp_if.source rsp_ch
);
   import sll_pkg::*;

   localparam int IW = $clog2(NODE_COUNT);
   localparam logic [IW-1:0] HEAD_IDX = IW'(HEAD_NODE);
   localparam logic [IW-1:0] NULL_IDX = '0;
   localparam logic [IW:0]   FILL_START = (IW+1)'(FIRST_FREE);
   localparam logic [IW:0]   FILL_LIMIT = (IW+1)'(NODE_COUNT);

   sll_state_type          state_ff, state_in;
   sll_kind_type           kind_ff, kind_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   steps_ff, steps_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [IW-1:0]          cur_ff, cur_in;
   logic [IW-1:0]          at_ff, at_in;
   logic [IW-1:0]          next_ff, next_in;
   logic [IW-1:0]          node_ff, node_in;
   logic                   pop_ff, pop_in;
   logic [IW-1:0]          head_link_ff, head_link_in;
   logic [IW-1:0]          free_head_ff, free_head_in;
   logic [IW:0]            fill_ff, fill_in;
   sll_status_type         status_ff, status_in;
   logic [WORD_WIDTH-1:0]  read_value_ff, read_value_in;

   sll_wr_en_type          wr_en;
   logic [IW-1:0]          rd_addr;
   logic [IW-1:0]          link_waddr, link_wdata, data_waddr;
   logic [IW-1:0]          link_rdata;
   logic [VALUE_WIDTH-1:0] data_rdata;
   logic [IW-1:0]          link_cur;
   logic                   req_xfer;

   logic [VALUE_WIDTH+WORD_WIDTH-1:0] wr_wide;
   logic [VALUE_WIDTH+WORD_WIDTH-1:0] rd_wide;

   // Node storage.
   sll_store #(
      .NODE_COUNT  (NODE_COUNT),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .rd_addr    (rd_addr),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .data_waddr (data_waddr),
      .data_wdata (value_ff),
      .link_rdata (link_rdata),
      .data_rdata (data_rdata)
   );

   // Width adaptation of the stored value in both directions.
   assign wr_wide  = {{VALUE_WIDTH{1'b0}}, req_ch.new_value};
   assign rd_wide  = {{WORD_WIDTH{1'b0}}, data_rdata};
   assign req_xfer = req_ch.valid && req_ch.ready;

   // The head node's link lives in a register; all other links in memory.
   assign link_cur = (cur_ff == HEAD_IDX) ? head_link_ff : link_rdata;

   // Sequencer state and list registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_link_ff <= NULL_IDX;
         free_head_ff <= NULL_IDX;
         fill_ff      <= FILL_START;
      end else begin
         state_ff     <= state_in;
         head_link_ff <= head_link_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      steps_ff      <= steps_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      at_ff         <= at_in;
      next_ff       <= next_in;
      node_ff       <= node_in;
      pop_ff        <= pop_in;
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
   end

   // Next state, storage control and result.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      steps_in      = steps_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      at_in         = at_ff;
      next_in       = next_ff;
      node_in       = node_ff;
      pop_in        = pop_ff;
      head_link_in  = head_link_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      status_in     = status_ff;
      read_value_in = read_value_ff;
      wr_en         = '{link_we: 1'b0, data_we: 1'b0};
      rd_addr       = cur_ff;
      link_waddr    = node_ff;
      link_wdata    = next_ff;
      data_waddr    = node_ff;
      req_ch.ready  = 1'b0;
      rsp_ch.valid  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_xfer) begin
               kind_in       = sll_kind_type'(req_ch.kind);
               pos_in        = req_ch.position;
               value_in      = wr_wide[VALUE_WIDTH-1:0];
               cur_in        = HEAD_IDX;
               steps_in      = '0;
               status_in     = STATUS_OK;
               read_value_in = '0;
               if (sll_kind_type'(req_ch.kind) == KIND_CLEAR) begin
                  // Empty list, every node free again.
                  head_link_in = NULL_IDX;
                  free_head_in = NULL_IDX;
                  fill_in      = FILL_START;
                  state_in     = ST_RESP;
               end else if (sll_kind_type'(req_ch.kind) == KIND_READ &&
                            req_ch.position == '0) begin
                  status_in = STATUS_BAD_POS;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (steps_ff == pos_ff) begin
               // Arrived at the node named by the position.
               at_in   = cur_ff;
               next_in = link_cur;
               case (kind_ff)
                  KIND_INSERT: begin
                     if (free_head_ff != NULL_IDX) begin
                        node_in  = free_head_ff;
                        pop_in   = 1'b1;
                        rd_addr  = free_head_ff;
                        state_in = ST_INS;
                     end else if (fill_ff != FILL_LIMIT) begin
                        node_in  = fill_ff[IW-1:0];
                        fill_in  = fill_ff + 1'b1;
                        pop_in   = 1'b0;
                        state_in = ST_INS;
                     end else begin
                        status_in = STATUS_FULL;
                        state_in  = ST_RESP;
                     end
                  end
                  KIND_DELETE: begin
                     if (link_cur == NULL_IDX) begin
                        status_in = STATUS_BAD_POS;
                        state_in  = ST_RESP;
                     end else begin
                        node_in  = link_cur;
                        rd_addr  = link_cur;
                        state_in = ST_DEL;
                     end
                  end
                  KIND_READ: begin
                     read_value_in = rd_wide[WORD_WIDTH-1:0];
                     state_in      = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end else if (link_cur == NULL_IDX) begin
               // The list ends before the position.
               status_in = STATUS_BAD_POS;
               state_in  = ST_RESP;
            end else begin
               // Follow one link; its successor is read for the next cycle.
               cur_in   = link_cur;
               steps_in = steps_ff + 1'b1;
               rd_addr  = link_cur;
            end
         end

         ST_INS: begin
            // New node takes the value and the old successor.
            if (pop_ff) begin
               free_head_in = link_rdata;
            end
            wr_en      = '{link_we: 1'b1, data_we: 1'b1};
            link_waddr = node_ff;
            link_wdata = next_ff;
            state_in   = ST_INS_LINK;
         end

         ST_INS_LINK: begin
            // Predecessor now points to the new node.
            if (at_ff == HEAD_IDX) begin
               head_link_in = node_ff;
            end else begin
               wr_en.link_we = 1'b1;
               link_waddr    = at_ff;
               link_wdata    = node_ff;
            end
            state_in = ST_RESP;
         end

         ST_DEL: begin
            // Removed node joins the front of the free chain.
            read_value_in = rd_wide[WORD_WIDTH-1:0];
            next_in       = link_rdata;
            wr_en.link_we = 1'b1;
            link_waddr    = node_ff;
            link_wdata    = free_head_ff;
            free_head_in  = node_ff;
            state_in      = ST_DEL_LINK;
         end

         ST_DEL_LINK: begin
            // Predecessor skips the removed node.
            if (at_ff == HEAD_IDX) begin
               head_link_in = next_ff;
            end else begin
               wr_en.link_we = 1'b1;
               link_waddr    = at_ff;
               link_wdata    = next_ff;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.status     = status_ff;
   assign rsp_ch.read_value = read_value_ff;

`ifndef NO_ASSERTIONS
   // Only one item is in flight, so a request is never taken while a response waits.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request accepted while a response is pending");

   // The fill mark stays between the first free node and the node count.
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff >= FILL_START) && (fill_ff <= FILL_LIMIT))
      else $error("fill mark out of range");

   // The walk never goes past the requested position.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (steps_ff <= pos_ff))
      else $error("walk passed the requested position");

   // A clear is answered in the next cycle with status ok.
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && sll_kind_type'(req_ch.kind) == KIND_CLEAR) |=>
      (rsp_ch.valid && rsp_ch.status == STATUS_OK))
      else $error("clear not answered with ok");

   // A deleted node heads the free chain once the delete completes.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEL) |=> (free_head_ff == $past(node_ff)))
      else $error("deleted node not returned to the free chain");
`endif

endmodule

[design/sll_store.sv]
`timescale 1ns / 1ps
// ============================================================================
// sll_store
// Node storage: a link memory and a data memory, each with one write port
// and one shared read address, read data registered.
// ============================================================================
module sll_store #(
   parameter int NODE_COUNT  = 128,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  sll_pkg::sll_wr_en_type        wr_en,
   input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
   input  logic [$clog2(NODE_COUNT)-1:0] link_waddr,
   input  logic [$clog2(NODE_COUNT)-1:0] link_wdata,
   input  logic [$clog2(NODE_COUNT)-1:0] data_waddr,
   input  logic [VALUE_WIDTH-1:0]        data_wdata,
   output logic [$clog2(NODE_COUNT)-1:0] link_rdata,
   output logic [VALUE_WIDTH-1:0]        data_rdata
);
   import sll_pkg::*;

   localparam int IW = $clog2(NODE_COUNT);

   logic [IW-1:0]          link_mem_ff [NODE_COUNT];
   logic [VALUE_WIDTH-1:0] data_mem_ff [NODE_COUNT];
   logic [IW-1:0]          link_rdata_ff;
   logic [VALUE_WIDTH-1:0] data_rdata_ff;

   // Link memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en.link_we) begin
         link_mem_ff[link_waddr] <= link_wdata;
      end
      link_rdata_ff <= link_mem_ff[rd_addr];
   end

   // Data memory: same organization, same read address.
   always_ff @(posedge clock) begin
      if (wr_en.data_we) begin
         data_mem_ff[data_waddr] <= data_wdata;
      end
      data_rdata_ff <= data_mem_ff[rd_addr];
   end

   assign link_rdata = link_rdata_ff;
   assign data_rdata = data_rdata_ff;

endmodule
